[design/flc_pkg.sv]
package flc_pkg;

    localparam int DEF_MAX_TAPS    = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Widths fixed by the port list.
    localparam int IN_W   = 16;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 5;
    localparam int ACC_W  = 40;

    localparam logic REQ_COEFF = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift;
        logic tail_shift;
        logic clear;
        logic mul_en;
    } cell_ctrl_t;

endpackage

[design/flc_cell.sv]
module flc_cell #(
    parameter int SAMPLE_BITS = flc_pkg::DEF_SAMPLE_BITS,
    parameter int TAP_W       = 5,
    parameter int INDEX       = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  flc_pkg::cell_ctrl_t             ctrl,
    input  logic [TAP_W-1:0]                taps,
    input  logic                            coeff_we,
    input  logic [flc_pkg::IDX_W-1:0]       coeff_index,
    input  logic signed [SAMPLE_BITS-1:0]   coeff_data,
    input  logic signed [SAMPLE_BITS-1:0]   sample_in,
    output logic signed [SAMPLE_BITS-1:0]   sample_out,
    input  logic signed [flc_pkg::ACC_W-1:0] sum_in,
    output logic signed [flc_pkg::ACC_W-1:0] sum_out
);

    localparam int PW = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0]    coeff_reg;
    logic signed [SAMPLE_BITS-1:0]    sample_reg;
    logic signed [flc_pkg::ACC_W-1:0] prod_reg;
    logic signed [flc_pkg::ACC_W-1:0] sum_reg;
    logic signed [PW-1:0]             mult;
    logic signed [flc_pkg::ACC_W-1:0] mult_ext;
    logic                             active;

    assign active = 32'(taps) > INDEX;
    assign mult   = coeff_reg * sample_reg;

    // The sum wraps at the output width, so wide products keep only their low bits.
    generate
        if (PW >= flc_pkg::ACC_W) begin : g_trunc
            assign mult_ext = mult[flc_pkg::ACC_W-1:0];
        end
        else begin : g_sext
            assign mult_ext = {{(flc_pkg::ACC_W-PW){mult[PW-1]}}, mult};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            coeff_reg  <= '0;
            sample_reg <= '0;
        end
        else begin
            if (coeff_we && (32'(coeff_index) == INDEX)) begin
                coeff_reg <= coeff_data;
            end
            if (ctrl.clear) begin
                sample_reg <= '0;
            end
            else if (ctrl.shift) begin
                sample_reg <= sample_in;
            end
        end
    end

    // The partial sum moves one cell per cycle; after a full pass the last
    // cell holds the dot product of the frozen products.
    always_ff @(posedge clk) begin
        if (ctrl.mul_en) begin
            prod_reg <= active ? mult_ext : '0;
        end
        sum_reg <= sum_in + prod_reg;
    end

    assign sample_out = sample_reg;
    assign sum_out    = sum_reg;

endmodule

[design/flc_ctrl.sv]
module flc_ctrl #(
    parameter int MAX_TAPS = flc_pkg::DEF_MAX_TAPS,
    parameter int TAP_W    = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [flc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic                             last_sample,
    input  logic signed [flc_pkg::ACC_W-1:0] sum,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [flc_pkg::ACC_W-1:0] filtered_value,
    output logic                             last_result,
    output flc_pkg::cell_ctrl_t              cell_ctrl,
    output logic [TAP_W-1:0]                 taps,
    output logic                             coeff_we
);

    flc_pkg::state_t              state_reg, state_next;
    logic [flc_pkg::CFG_W-1:0]    tap_count_reg;
    logic [TAP_W-1:0]             remain_reg, remain_next;
    logic [TAP_W-1:0]             cnt_reg, cnt_next;
    logic                         last_reg, last_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [flc_pkg::ACC_W-1:0] filtered_value_reg;
    logic                         last_result_reg;
    logic                         out_load;

    always_comb begin
        if (32'(tap_count_reg) > MAX_TAPS) begin
            taps = TAP_W'(MAX_TAPS);
        end
        else begin
            taps = TAP_W'(tap_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= flc_pkg::ST_IDLE;
            tap_count_reg <= flc_pkg::CFG_W'(1);
            remain_reg    <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                tap_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            filtered_value_reg <= sum;
            last_result_reg    <= last_reg && (remain_reg == '0);
        end
    end

    always_comb begin
        state_next  = state_reg;
        remain_next = remain_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        in_ready    = 1'b0;
        coeff_we    = 1'b0;
        out_load    = 1'b0;
        cell_ctrl   = '0;

        unique case (state_reg)
            flc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (req_type == flc_pkg::REQ_COEFF) begin
                        coeff_we = 1'b1;
                    end
                    else begin
                        cell_ctrl.shift = 1'b1;
                        if (taps == '0) begin
                            // No output at all, but the last word still ends the sequence.
                            cell_ctrl.clear = last_sample;
                        end
                        else begin
                            state_next  = flc_pkg::ST_MUL;
                            last_next   = last_sample;
                            remain_next = last_sample ? (taps - TAP_W'(1)) : '0;
                        end
                    end
                end
            end
            flc_pkg::ST_MUL: begin
                cell_ctrl.mul_en = 1'b1;
                cnt_next         = '0;
                state_next       = flc_pkg::ST_SUM;
            end
            flc_pkg::ST_SUM: begin
                cnt_next = cnt_reg + TAP_W'(1);
                if (cnt_reg == TAP_W'(MAX_TAPS - 1)) begin
                    state_next = flc_pkg::ST_EMIT;
                end
            end
            flc_pkg::ST_EMIT: begin
                if (!out_valid_reg || out_ready) begin
                    out_load = 1'b1;
                    if (remain_reg != '0) begin
                        // Tail of the sequence: feed zeros past the last sample.
                        remain_next          = remain_reg - TAP_W'(1);
                        cell_ctrl.shift      = 1'b1;
                        cell_ctrl.tail_shift = 1'b1;
                        state_next           = flc_pkg::ST_MUL;
                    end
                    else begin
                        cell_ctrl.clear = last_reg;
                        state_next      = flc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = flc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filtered_value_reg;
    assign last_result    = last_result_reg;

endmodule

[design/full_linear_convolution_fir.sv]
// Full linear convolution FIR filter, Q1.15 in, full-precision Q.30 out.
// Input channel (in_valid/in_ready): each word is a coefficient write
// (req_type 0, coeff_index, sample_or_coeff) or a sample (req_type 1);
// last_sample marks the end of a sequence. A sample gives one result, and
// the last sample also gives min(tap_count,MAX_TAPS)-1 tail results, the final
// one carrying last_result. Output channel (out_valid/out_ready): one register.
// cfg_wr_en/cfg_wr_data write tap_count (0 gives no results at all).
// Steps: a sample is shifted in, the products are formed (ST_MUL), the partial
// sum walks the row of tap cells one cell per cycle (ST_SUM), and the result is
// loaded into the output register (ST_EMIT); each tail result repeats these steps.
// Coefficient words are accepted back to back while idle. The input is not taken
// while a sample or its tail is being worked on.
// When the receiver stalls, the finished result waits in the output register
// and the next result waits in the cells; a new word is still accepted while
// the output register is full once the block is back to idle.
// Reset clears the kernel and the delay line and sets tap_count to 1.
module full_linear_convolution_fir #(
    parameter int MAX_TAPS    = flc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = flc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [flc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [flc_pkg::IDX_W-1:0]        coeff_index,
    input  logic signed [flc_pkg::IN_W-1:0]  sample_or_coeff,
    input  logic                             last_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [flc_pkg::ACC_W-1:0] filtered_value,
    output logic                             last_result
);

    localparam int TAP_W = $clog2(MAX_TAPS + 1);

    flc_pkg::cell_ctrl_t              cell_ctrl;
    logic [TAP_W-1:0]                 taps;
    logic                             coeff_we;
    logic signed [SAMPLE_BITS-1:0]    sample_ext;
    logic signed [SAMPLE_BITS-1:0]    sample_chain [0:MAX_TAPS];
    logic signed [flc_pkg::ACC_W-1:0] sum_chain    [0:MAX_TAPS];

    // Narrow samples keep their low bits as a signed value; wider ones see
    // the port as an unsigned pattern.
    generate
        if (SAMPLE_BITS == flc_pkg::IN_W) begin : g_same
            assign sample_ext = sample_or_coeff;
        end
        else if (SAMPLE_BITS > flc_pkg::IN_W) begin : g_wide
            assign sample_ext = {{(SAMPLE_BITS-flc_pkg::IN_W){1'b0}}, sample_or_coeff};
        end
        else begin : g_narrow
            assign sample_ext = sample_or_coeff[SAMPLE_BITS-1:0];
        end
    endgenerate

    assign sample_chain[0] = cell_ctrl.tail_shift ? '0 : sample_ext;
    assign sum_chain[0]    = '0;

    flc_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .TAP_W    (TAP_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .last_sample    (last_sample),
        .sum            (sum_chain[MAX_TAPS]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .last_result    (last_result),
        .cell_ctrl      (cell_ctrl),
        .taps           (taps),
        .coeff_we       (coeff_we)
    );

    generate
        for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
            flc_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .TAP_W       (TAP_W),
                .INDEX       (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .taps        (taps),
                .coeff_we    (coeff_we),
                .coeff_index (coeff_index),
                .coeff_data  (sample_ext),
                .sample_in   (sample_chain[i]),
                .sample_out  (sample_chain[i+1]),
                .sum_in      (sum_chain[i]),
                .sum_out     (sum_chain[i+1])
            );
        end
    endgenerate

endmodule
